/* rtl/windowed_waveform_generator_macros.svh */
// Assertion macros for the windowed waveform generator.
// Used by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef WINDOWED_WAVEFORM_GENERATOR_MACROS_SVH
`define WINDOWED_WAVEFORM_GENERATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WWG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wwg: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define WWG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wwg: next-cycle check failed");

`endif

/* rtl/wwg_pkg.sv */
// Shared constants, codes and types of the windowed waveform generator.
// No dependencies; the top level and the sine unit refer to it by scoped names.
package wwg_pkg;

  localparam int MAX_WINDOWS  = 8;
  localparam int MAX_ELEMENTS = 16;
  localparam int WIN_AW       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int WIN_DW       = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Polynomial coefficients of the quarter-wave sine.
  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [16:0] POLY_B = 17'd42047;
  localparam logic [16:0] POLY_C = 17'd4640;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_COS    = 2'd1,
    SHAPE_SQUARE = 2'd2
  } wwg_shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_SHAPE   = 3'd0,
    CFG_AMPLITUDE    = 3'd1,
    CFG_PHASE_STEP   = 3'd2,
    CFG_WINDOW_COUNT = 3'd3,
    CFG_ELEMENTS     = 3'd4
  } wwg_cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic [1:0]         shape;
    logic signed [15:0] amp;
    logic [31:0]        phase;
  } wwg_unit_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [15:0] value;
  } wwg_unit_sts_t;

endpackage

/* rtl/wwg_in_if.sv */
// Input channel of the windowed waveform generator: load and tick items.
// Stand-alone interface, no dependencies.
interface wwg_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  window_slot;
  logic [31:0] window_start;
  logic [31:0] window_end;
  logic [31:0] time_us;

  modport source (output valid, command, window_slot, window_start, window_end, time_us,
                  input ready);
  modport sink   (input valid, command, window_slot, window_start, window_end, time_us,
                  output ready);
endinterface

/* rtl/wwg_out_if.sv */
// Result channel of the windowed waveform generator: one sample per transfer.
// Stand-alone interface, no dependencies.
interface wwg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [3:0]         element_index;
  logic               last;

  modport source (output valid, sample, element_index, last, input ready);
  modport sink   (input valid, sample, element_index, last, output ready);
endinterface

/* rtl/windowed_waveform_generator.sv */
// Top level of the windowed waveform generator: window store, tick sequencer, output register.
// Depends on wwg_pkg, wwg_in_if, wwg_out_if, wwg_ram, wwg_sine_unit and the macro header.
//
//   channel   direction  content
//   in_chan   sink       load (slot, start, end) or tick (time_us)
//   out_chan  source     sample, element_index, last
//   cfg_*     write      shape, amplitude, phase step, window count, elements
//
// A load leaves the block idle and ready. A tick reads the active window in the cycle after
// its transfer and ends there when it lies outside the window or no elements are set; no
// new item is taken until it ends. Inside a window, the base state computes the base phase
// and the sine unit then computes each sample; its shared 17x17 multiplier yields one product
// per cycle. Reset clears the window store's valid bits at once; no clearing pass is needed.
// A stalled output holds the finished sample in its register while the next one is computed.
`include "windowed_waveform_generator_macros.svh"

module windowed_waveform_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  wwg_in_if.sink                           in_chan,
  wwg_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [wwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wwg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_BASE  = 5'b00100,
    ST_ELEM  = 5'b01000,
    ST_WAIT  = 5'b10000
  } seq_state_t;

  localparam logic [6:0] MaxWin  = 7'(wwg_pkg::MAX_WINDOWS);
  localparam logic [6:0] MaxElem = 7'(wwg_pkg::MAX_ELEMENTS);

  // Configuration registers.
  logic [1:0]         wave_shape_r;
  logic signed [15:0] amplitude_r;
  logic [31:0]        phase_step_r;
  logic [3:0]         window_count_r;
  logic [4:0]         elements_r;

  seq_state_t                   state_r, state_nxt;
  logic [wwg_pkg::WIN_AW-1:0]   aw_r, aw_nxt;
  logic [wwg_pkg::MAX_WINDOWS-1:0] win_valid_r, win_valid_nxt;
  logic                         rd_valid_r;
  logic [31:0]                  time_r;
  logic [31:0]                  base_r;
  logic [31:0]                  phase_r;
  logic [4:0]                   idx_r;
  logic [4:0]                   n_r;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [15:0]           sample_r;
  logic [3:0]                   index_r;
  logic                         last_r;

  logic                         in_xfer, load_xfer, tick_xfer;
  logic                         slot_ok, ram_we;
  logic [wwg_pkg::WIN_AW-1:0]   ram_waddr;
  logic [wwg_pkg::WIN_DW-1:0]   ram_rdata;
  logic [31:0]                  win_start, win_end;
  logic                         in_window, past_window;
  logic [6:0]                   count_eff, aw_inc;
  logic [4:0]                   n_eff;
  logic                         out_xfer, out_free, load_out, is_last;
  logic [31:0]                  base_prod;

  wwg_pkg::wwg_unit_req_t       unit_req;
  wwg_pkg::wwg_unit_sts_t       unit_sts;

  // Input side: new items only while the sequencer is idle.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign load_xfer = in_xfer && (in_chan.command == wwg_pkg::CMD_LOAD);
  assign tick_xfer = in_xfer && (in_chan.command == wwg_pkg::CMD_TICK);

  // A load to a slot beyond the store is dropped.
  assign slot_ok   = ({29'b0, in_chan.window_slot} < 32'(wwg_pkg::MAX_WINDOWS));
  assign ram_we    = load_xfer && slot_ok;
  assign ram_waddr = wwg_pkg::WIN_AW'(in_chan.window_slot);

  wwg_ram #(
    .DEPTH(wwg_pkg::MAX_WINDOWS),
    .WIDTH(wwg_pkg::WIN_DW)
  ) u_win_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_chan.window_start, in_chan.window_end}),
    .re    (tick_xfer),
    .raddr (aw_r),
    .rdata (ram_rdata)
  );

  // An entry never loaded since reset reads as a zero window.
  assign win_start = rd_valid_r ? ram_rdata[63:32] : 32'd0;
  assign win_end   = rd_valid_r ? ram_rdata[31:0]  : 32'd0;

  assign in_window   = (win_start <= time_r) && (time_r <= win_end);
  assign past_window = (time_r > win_end);

  // Window count of zero acts as one; counts above the store size act as the store size.
  always_comb begin
    count_eff = 7'(window_count_r);
    if (count_eff == 7'd0) begin
      count_eff = 7'd1;
    end else if (count_eff > MaxWin) begin
      count_eff = MaxWin;
    end
  end

  assign aw_inc = 7'(aw_r) + 7'd1;
  assign n_eff  = (7'(elements_r) > MaxElem) ? 5'(wwg_pkg::MAX_ELEMENTS) : elements_r;

  // Only the low word of the product is needed: the phase wraps modulo one turn.
  assign base_prod = phase_step_r * time_r;

  // Output register: a finished sample moves in when the register is empty or draining.
  assign out_xfer = out_valid_r && out_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign load_out = (state_r == ST_WAIT) && unit_sts.done && out_free;
  assign is_last  = ((6'(idx_r) + 6'd1) == 6'(n_r));

  // The sine unit starts one sample per visit to the element state; cosine is a quarter
  // turn ahead.
  always_comb begin
    unit_req.start = (state_r == ST_ELEM);
    unit_req.shape = wave_shape_r;
    unit_req.amp   = amplitude_r;
    unit_req.phase = (wave_shape_r == wwg_pkg::SHAPE_COS) ?
                     (phase_r + wwg_pkg::QUARTER_TURN) : phase_r;
  end

  wwg_sine_unit u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .sts   (unit_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    aw_nxt        = aw_r;
    win_valid_nxt = win_valid_r;
    out_valid_nxt = out_valid_r;

    if (ram_we) begin
      win_valid_nxt[ram_waddr] = 1'b1;
    end

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (tick_xfer) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_window) begin
          state_nxt = (n_eff == 5'd0) ? ST_IDLE : ST_BASE;
        end else begin
          state_nxt = ST_IDLE;
          // Past the window's end: move on to the next window, wrapping after the last.
          if (past_window) begin
            aw_nxt = (aw_inc >= count_eff) ? '0 : wwg_pkg::WIN_AW'(aw_inc);
          end
        end
      end
      ST_BASE: state_nxt = ST_ELEM;
      ST_ELEM: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (load_out) begin
          state_nxt = is_last ? ST_IDLE : ST_ELEM;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      aw_r           <= '0;
      win_valid_r    <= '0;
      out_valid_r    <= 1'b0;
      wave_shape_r   <= 2'd0;
      amplitude_r    <= 16'sd0;
      phase_step_r   <= 32'd0;
      window_count_r <= 4'd1;
      elements_r     <= 5'd1;
    end else begin
      state_r     <= state_nxt;
      aw_r        <= aw_nxt;
      win_valid_r <= win_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          wwg_pkg::CFG_WAVE_SHAPE:   wave_shape_r   <= cfg_data[1:0];
          wwg_pkg::CFG_AMPLITUDE:    amplitude_r    <= $signed(cfg_data[15:0]);
          wwg_pkg::CFG_PHASE_STEP:   phase_step_r   <= cfg_data;
          wwg_pkg::CFG_WINDOW_COUNT: window_count_r <= cfg_data[3:0];
          wwg_pkg::CFG_ELEMENTS:     elements_r     <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      time_r     <= in_chan.time_us;
      rd_valid_r <= win_valid_r[aw_r];
    end
    if (state_r == ST_CHECK) begin
      n_r <= n_eff;
    end
    if (state_r == ST_BASE) begin
      base_r  <= base_prod;
      phase_r <= 32'd0;
      idx_r   <= 5'd0;
    end
    if (load_out) begin
      sample_r <= unit_sts.value;
      index_r  <= idx_r[3:0];
      last_r   <= is_last;
      idx_r    <= idx_r + 5'd1;
      phase_r  <= phase_r + base_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.sample        = sample_r;
  assign out_chan.element_index = index_r;
  assign out_chan.last          = last_r;

  // A tick always goes to the window check in the next cycle.
  `WWG_ASSERT_NEXT(a_tick_to_check, tick_xfer, state_r == ST_CHECK)
  // More samples of a run are still under way whenever a non-final one transfers.
  `WWG_ASSERT_SAME(a_run_pending, out_xfer && !out_chan.last,
                   state_r == ST_ELEM || state_r == ST_WAIT)
  // The sine unit is never started while it is still working.
  `WWG_ASSERT_SAME(a_unit_free, unit_req.start, !unit_sts.busy)

endmodule

/* rtl/wwg_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module wwg_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/wwg_sine_unit.sv */
// Multi-cycle sine and scaling unit: one Q0.32 phase in, one signed sample out.
// Depends on wwg_pkg for coefficients, shape codes and the request/status structs.
module wwg_sine_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wwg_pkg::wwg_unit_req_t req,
  output wwg_pkg::wwg_unit_sts_t sts
);

  typedef enum logic [9:0] {
    U_IDLE = 10'b00_0000_0001,
    U_X2   = 10'b00_0000_0010,
    U_X3   = 10'b00_0000_0100,
    U_X5   = 10'b00_0000_1000,
    U_PA   = 10'b00_0001_0000,
    U_PC   = 10'b00_0010_0000,
    U_PB   = 10'b00_0100_0000,
    U_SIN  = 10'b00_1000_0000,
    U_MUL  = 10'b01_0000_0000,
    U_RND  = 10'b10_0000_0000
  } unit_state_t;

  unit_state_t        state_r, state_nxt;
  logic               done_r, done_nxt;

  logic [16:0]        x_r, x2_r, x3_r, x5_r;
  logic [1:0]         q_r;
  logic [1:0]         shape_r;
  logic signed [15:0] amp_r;
  logic [34:0]        acc_r;
  logic signed [16:0] m_r;
  logic signed [32:0] prod_r;
  logic signed [15:0] value_r;

  logic [15:0]        frac;
  logic [16:0]        x_in;
  logic [16:0]        mul_a, mul_b;
  logic [33:0]        mul_p;
  logic [34:0]        mul_ext;
  logic [34:0]        round_sum;
  logic [17:0]        s_full;
  logic [15:0]        s_mag;
  logic signed [16:0] m_val;
  logic [32:0]        mag;
  logic [32:0]        mag_sum;
  logic [17:0]        r_val;
  logic signed [15:0] val;

  // Quarter-wave argument, mirrored in the second and fourth quadrants.
  assign frac = req.phase[29:14];
  assign x_in = req.phase[30] ? (17'h1_0000 - {1'b0, frac}) : {1'b0, frac};

  // One shared unsigned multiplier serves the powers and the coefficient products.
  always_comb begin
    case (state_r)
      U_X2:    begin mul_a = x_r;    mul_b = x_r;  end
      U_X3:    begin mul_a = x2_r;   mul_b = x_r;  end
      U_X5:    begin mul_a = x3_r;   mul_b = x2_r; end
      U_PA:    begin mul_a = wwg_pkg::POLY_A; mul_b = x_r;  end
      U_PC:    begin mul_a = wwg_pkg::POLY_C; mul_b = x5_r; end
      U_PB:    begin mul_a = wwg_pkg::POLY_B; mul_b = x3_r; end
      default: begin mul_a = '0;     mul_b = '0;   end
    endcase
  end

  assign mul_p   = {17'b0, mul_a} * {17'b0, mul_b};
  assign mul_ext = {1'b0, mul_p};

  // Round the polynomial to Q15 and clamp at full scale.
  assign round_sum = acc_r + 35'd65536;
  assign s_full    = round_sum[34:17];
  assign s_mag     = (s_full > 18'd32768) ? 16'h8000 : s_full[15:0];
  assign m_val     = q_r[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

  // Scale by amplitude, rounding half away from zero, then saturate.
  assign mag     = prod_r[32] ? 33'(-prod_r) : 33'(prod_r);
  assign mag_sum = mag + 33'd16384;
  assign r_val   = mag_sum[32:15];

  always_comb begin
    case (shape_r)
      wwg_pkg::SHAPE_SINE, wwg_pkg::SHAPE_COS: begin
        if (prod_r[32]) begin
          val = 16'(-r_val);
        end else if (r_val > 18'd32767) begin
          val = 16'sh7FFF;
        end else begin
          val = 16'(r_val);
        end
      end
      wwg_pkg::SHAPE_SQUARE: begin
        if (m_r < 0) begin
          val = (amp_r == -16'sd32768) ? 16'sh7FFF : -amp_r;
        end else begin
          val = amp_r;
        end
      end
      default: val = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          state_nxt = U_X2;
          done_nxt  = 1'b0;
        end
      end
      U_X2:  state_nxt = U_X3;
      U_X3:  state_nxt = U_X5;
      U_X5:  state_nxt = U_PA;
      U_PA:  state_nxt = U_PC;
      U_PC:  state_nxt = U_PB;
      U_PB:  state_nxt = U_SIN;
      U_SIN: state_nxt = U_MUL;
      U_MUL: state_nxt = U_RND;
      U_RND: begin
        state_nxt = U_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          x_r     <= x_in;
          q_r     <= req.phase[31:30];
          shape_r <= req.shape;
          amp_r   <= req.amp;
        end
      end
      U_X2:  x2_r   <= mul_p[32:16];
      U_X3:  x3_r   <= mul_p[32:16];
      U_X5:  x5_r   <= mul_p[32:16];
      U_PA:  acc_r  <= mul_ext;
      U_PC:  acc_r  <= acc_r + mul_ext;
      U_PB:  acc_r  <= (mul_ext > acc_r) ? '0 : (acc_r - mul_ext);
      U_SIN: m_r    <= m_val;
      U_MUL: prod_r <= amp_r * m_r;
      U_RND: value_r <= val;
      default: ;
    endcase
  end

  assign sts.busy  = (state_r != U_IDLE);
  assign sts.done  = done_r;
  assign sts.value = value_r;

endmodule
